[src/psem_pkg.sv]
// Shared types and constants for the priority counting semaphore.
// Holds field widths, command and status codes and the control state type.
// No dependencies.
package psem_pkg;

    localparam int CMD_W    = 1;
    localparam int TASK_W   = 3;
    localparam int PRIO_W   = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;
    localparam int INIT_W   = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'sh7F;
    localparam logic [COUNT_W-1:0] COUNT_MIN = 8'sh80;
    localparam logic [COUNT_W-1:0] COUNT_RST = 8'sh01;

    typedef enum logic [CMD_W-1:0] {
        CMD_WAIT   = 1'b0,
        CMD_SIGNAL = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_GRANTED  = 2'd0,
        STAT_BLOCKED  = 2'd1,
        STAT_SIGNALED = 2'd2,
        STAT_WOKE     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEVEL,
        ST_LINK
    } t_state;

endpackage

[src/psem_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the per-level head/tail table and the task link table.
// No dependencies.
module psem_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 3
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/priority_counting_semaphore_core.sv]
// Top level of the priority counting semaphore: count, waiting bitmap,
// control sequencer and output register. Uses psem_pkg and two psem_ram.
//
//   channel   | direction | ports           | contents
//   ----------+-----------+-----------------+----------------------------------
//   request   | in        | s_axis_*        | tuser: command; tdata: task_id,
//             |           |                 |   task_priority
//   result    | out       | m_axis_*        | tuser: status; tdata: woken_task,
//             |           |                 |   count_now
//   config    | in        | i_cfg_*         | initial_count, reloads semaphore
//
// An item is accepted, then one head/tail table read follows; a wakeup that leaves
// waiters on its level adds a link table read, since the link table read depends on
// the head just read from the level table.
// Reset is synchronous and needs no clearing pass; table entries are only
// read behind a set waiting bit. A result waits in the output register while
// the next item is taken; that item holds in its last step until the slot
// frees.
module priority_counting_semaphore_core #(
    parameter int NUM_TASKS       = 8,
    parameter int PRIORITY_LEVELS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [2:0] task_id, [5:3] task_priority
    input  logic [0:0]  s_axis_tuser,   // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [2:0] woken_task, [10:3] count_now
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data      // [6:0] initial_count
);

    localparam int TW = $clog2(NUM_TASKS);
    localparam int LW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;

    function automatic logic [LW-1:0] clamp_level(logic [psem_pkg::PRIO_W-1:0] p);
        logic [LW-1:0] lv;
        if (32'(p) >= PRIORITY_LEVELS) lv = LW'(PRIORITY_LEVELS - 1);
        else                           lv = LW'(p);
        return lv;
    endfunction

    function automatic logic [TW-1:0] reduce_task(logic [psem_pkg::TASK_W-1:0] t);
        logic [psem_pkg::TASK_W:0] v;
        v = {1'b0, t};
        for (int i = 0; i < 4; i++) begin
            if (32'(v) >= NUM_TASKS) v = v - (psem_pkg::TASK_W + 1)'(NUM_TASKS);
        end
        return TW'(v);
    endfunction

    // lowest index first, so the highest set level wins
    function automatic logic [LW-1:0] top_level(logic [PRIORITY_LEVELS-1:0] b);
        logic [LW-1:0] lv;
        lv = '0;
        for (int i = 0; i < PRIORITY_LEVELS; i++) begin
            if (b[i]) lv = LW'(i);
        end
        return lv;
    endfunction

    psem_pkg::t_state           r_state, n_state;
    logic [psem_pkg::COUNT_W-1:0] r_count, n_count;
    logic [PRIORITY_LEVELS-1:0] r_wait, n_wait;
    psem_pkg::t_status          r_status, n_status;
    logic [TW-1:0]              r_task, n_task;
    logic [LW-1:0]              r_lvl, n_lvl;
    logic                       r_bit, n_bit;
    logic [TW-1:0]              r_head, n_head;
    logic                       r_m_valid, n_m_valid;
    logic [15:0]                r_m_data, n_m_data;
    logic [1:0]                 r_m_user, n_m_user;

    logic                       in_xfer;
    logic                       out_free;
    logic [LW-1:0]              acc_lvl;
    logic [LW-1:0]              lvl_raddr;
    logic                       lvl_we;
    logic [2*TW-1:0]            lvl_wdata;
    logic [2*TW-1:0]            lvl_q;
    logic [TW-1:0]              lvl_head, lvl_tail;
    logic [TW-1:0]              link_raddr;
    logic                       link_we;
    logic [TW-1:0]              link_q;
    logic                       load_out;
    logic [TW-1:0]              out_woken;

    assign s_axis_tready = (r_state == psem_pkg::ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign acc_lvl  = (s_axis_tuser[0] == psem_pkg::CMD_WAIT)
                    ? clamp_level(s_axis_tdata[5:3]) : top_level(r_wait);
    assign lvl_raddr = (r_state == psem_pkg::ST_IDLE) ? acc_lvl : r_lvl;
    assign lvl_head  = lvl_q[2*TW-1:TW];
    assign lvl_tail  = lvl_q[TW-1:0];
    assign link_raddr = (r_state == psem_pkg::ST_LINK) ? r_head : lvl_head;

    psem_ram #(.DEPTH(PRIORITY_LEVELS), .WIDTH(2*TW)) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (lvl_we),
        .i_waddr (r_lvl),
        .i_wdata (lvl_wdata),
        .i_raddr (lvl_raddr),
        .o_rdata (lvl_q)
    );

    psem_ram #(.DEPTH(NUM_TASKS), .WIDTH(TW)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (lvl_tail),
        .i_wdata (r_task),
        .i_raddr (link_raddr),
        .o_rdata (link_q)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_wait    = r_wait;
        n_status  = r_status;
        n_task    = r_task;
        n_lvl     = r_lvl;
        n_bit     = r_bit;
        n_head    = r_head;
        n_m_valid = r_m_valid && !m_axis_tready;
        lvl_we    = 1'b0;
        lvl_wdata = lvl_q;
        link_we   = 1'b0;
        load_out  = 1'b0;
        out_woken = '0;

        unique case (r_state)
            psem_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_task = reduce_task(s_axis_tdata[2:0]);
                    n_lvl  = acc_lvl;
                    n_bit  = r_wait[acc_lvl];
                    if (s_axis_tuser[0] == psem_pkg::CMD_WAIT) begin
                        if (r_count != psem_pkg::COUNT_MIN) n_count = r_count - 8'd1;
                        n_status = n_count[psem_pkg::COUNT_W-1] ? psem_pkg::STAT_BLOCKED
                                                                : psem_pkg::STAT_GRANTED;
                    end else begin
                        if (r_count != psem_pkg::COUNT_MAX) n_count = r_count + 8'd1;
                        n_status = (r_wait != '0) ? psem_pkg::STAT_WOKE
                                                  : psem_pkg::STAT_SIGNALED;
                    end
                    n_state = psem_pkg::ST_LEVEL;
                end
            end
            psem_pkg::ST_LEVEL: begin
                priority if (r_status == psem_pkg::STAT_WOKE && lvl_head != lvl_tail) begin
                    // level keeps waiters: fetch the successor first
                    n_head  = lvl_head;
                    n_state = psem_pkg::ST_LINK;
                end else if (out_free) begin
                    load_out = 1'b1;
                    n_state  = psem_pkg::ST_IDLE;
                    if (r_status == psem_pkg::STAT_BLOCKED) begin
                        lvl_we        = 1'b1;
                        lvl_wdata     = {(r_bit ? lvl_head : r_task), r_task};
                        link_we       = r_bit;
                        n_wait[r_lvl] = 1'b1;
                    end else if (r_status == psem_pkg::STAT_WOKE) begin
                        out_woken     = lvl_head;
                        n_wait[r_lvl] = 1'b0;
                    end
                end
            end
            psem_pkg::ST_LINK: begin
                if (out_free) begin
                    lvl_we    = 1'b1;
                    lvl_wdata = {link_q, lvl_tail};
                    out_woken = r_head;
                    load_out  = 1'b1;
                    n_state   = psem_pkg::ST_IDLE;
                end
            end
            default: n_state = psem_pkg::ST_IDLE;
        endcase

        n_m_data = r_m_data;
        n_m_user = r_m_user;
        if (load_out) begin
            n_m_valid = 1'b1;
            n_m_data  = {5'b0, r_count, 3'(out_woken)};
            n_m_user  = r_status;
        end

        // reload the semaphore on a configuration transfer
        if (i_cfg_valid && o_cfg_ready) begin
            n_count = {1'b0, i_cfg_data};
            n_wait  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= psem_pkg::ST_IDLE;
            r_count   <= psem_pkg::COUNT_RST;
            r_wait    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_wait    <= n_wait;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_task   <= n_task;
        r_lvl    <= n_lvl;
        r_bit    <= n_bit;
        r_head   <= n_head;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    a_link_after_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psem_pkg::ST_LINK && $past(r_state) != psem_pkg::ST_LINK)
        |-> $past(r_state) == psem_pkg::ST_LEVEL)
        else $error("link fetch entered without a level table read");

    a_woke_has_waiter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psem_pkg::ST_LEVEL && r_status == psem_pkg::STAT_WOKE)
        |-> r_wait[r_lvl])
        else $error("wakeup chose a level with no waiter");

    a_blocked_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_user == psem_pkg::STAT_BLOCKED) |-> r_m_data[10])
        else $error("blocked result with a non-negative count");

    a_granted_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_user == psem_pkg::STAT_GRANTED) |-> !r_m_data[10])
        else $error("granted result with a negative count");

endmodule
